// ===== src/modular_domain_reduce_core_macros.svh =====
// assertion macros for the modular domain reduce core
// used by the checker module only
`ifndef MODULAR_DOMAIN_REDUCE_CORE_MACROS_SVH
`define MODULAR_DOMAIN_REDUCE_CORE_MACROS_SVH

// same-cycle implication
`define MDR_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define MDR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== src/mdr_pkg.sv =====
// package for the modular domain reduce core
// types, sizes, state enum and helpers; no dependencies
package mdr_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SQ_BITS   = 2 * WORD_BITS;
  localparam int unsigned NUM_BITS  = 2 * WORD_BITS;
  localparam int unsigned DEN_BITS  = 2 * FRAC_BITS;
  localparam int unsigned CNT_BITS  = $clog2(NUM_BITS);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] z_re;
    logic signed [WORD_BITS-1:0] z_im;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] red_re;
    logic signed [WORD_BITS-1:0] red_im;
    logic                        in_domain;
    logic                        saturated;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_TRANS,
    ST_SQX,
    ST_SQY,
    ST_CHK,
    ST_DIVX,
    ST_DIVY,
    ST_DONE
  } state_e;

  function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] v);
    mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== src/mdr_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on mdr_pkg
module mdr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mdr_pkg::NUM_BITS-1:0]   num_i,
  input  logic [mdr_pkg::DEN_BITS-1:0]   den_i,
  output logic                           done_o,
  output logic [mdr_pkg::NUM_BITS-1:0]   quo_o
);
  import mdr_pkg::*;

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS-1:0] rem_q;
  logic [NUM_BITS-1:0] nq_q;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                take;

  assign trial = {rem_q, nq_q[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = (trial >= {1'b0, den_q});

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      nq_q  <= num_i;
    end else if (run_q) begin
      rem_q <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      nq_q  <= {nq_q[NUM_BITS-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

// ===== src/modular_domain_reduce_core.sv =====
// an item ends after max_rounds inversion rounds or earlier when the point stops early,
// so it runs at most max_rounds inversion rounds
// each inversion round: translate, two squarings, check, then two divisions
// busy stays high for the whole item; the next transfer can be taken in the cycle after the strobe
// the result strobe lasts one cycle and the receiver cannot stall it
// reset: asynchronous active low, max_rounds returns to 200, sequencer to idle
module modular_domain_reduce_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mdr_pkg::in_t  in_i,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  output logic          done_o,
  output mdr_pkg::out_t out_o
);
  import mdr_pkg::*;

  localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] FX_HALF = WORD_BITS'(1) << (FRAC_BITS - 1);

  state_e state_q, state_d;
  logic [7:0] max_rounds_q;
  logic [7:0] rnd_q;
  logic       fin_q;
  logic       sat_q;
  logic signed [WORD_BITS-1:0] x_q, y_q;
  logic [SQ_BITS-1:0] acc_q, d_q;

  logic [WORD_BITS-1:0]  ax, ay, mul_a;
  logic [SQ_BITS-1:0]    prod;
  logic [WORD_BITS+1:0]  rnd_sum, shift_amt;
  logic signed [WORD_BITS+1:0] xt;
  logic                  brk;
  logic                  div_start, div_done;
  logic [NUM_BITS-1:0]   div_num, quo;
  logic                  qx_sat, qy_sat;
  logic [WORD_BITS-1:0]  qx, qy;

  assign ax = mag(x_q);
  assign ay = mag(y_q);
  assign mul_a = (state_q == ST_SQX) ? ax : ay;
  assign prod  = SQ_BITS'(mul_a) * SQ_BITS'(mul_a);

  assign rnd_sum   = {2'b00, ax} + {2'b00, FX_HALF};
  assign shift_amt = (rnd_sum >> FRAC_BITS) << FRAC_BITS;
  assign xt = x_q[WORD_BITS-1] ? ({{2{x_q[WORD_BITS-1]}}, x_q} + $signed(shift_amt))
                               : ({{2{x_q[WORD_BITS-1]}}, x_q} - $signed(shift_amt));

  assign brk = (d_q[SQ_BITS-1:DEN_BITS] != '0) || (d_q == '0);

  function automatic logic [WORD_BITS:0] sat_quot(input logic neg, input logic [NUM_BITS-1:0] q);
    logic [WORD_BITS:0] r;
    if (neg) begin
      if (q > NUM_BITS'(W_MIN)) r = {1'b1, W_MIN};
      else r = {1'b0, WORD_BITS'(~q + 1'b1)};
    end else begin
      if (q > NUM_BITS'(W_MAX)) r = {1'b1, W_MAX};
      else r = {1'b0, q[WORD_BITS-1:0]};
    end
    sat_quot = r;
  endfunction

  assign {qx_sat, qx} = sat_quot(!x_q[WORD_BITS-1] && (x_q != '0), quo);
  assign {qy_sat, qy} = sat_quot(y_q[WORD_BITS-1], quo);

  mdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (d_q[DEN_BITS-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_ROUND;
      ST_ROUND: state_d = (rnd_q == max_rounds_q) ? ST_SQX : ST_TRANS;
      ST_TRANS: state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = fin_q ? ST_DONE : ST_CHK;
      ST_CHK:   state_d = brk ? ST_DONE : ST_DIVX;
      ST_DIVX:  if (div_done) state_d = ST_DIVY;
      ST_DIVY:  if (div_done) state_d = ST_ROUND;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and divider control
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    busy      = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_CHK: begin
        div_start = !brk;
        div_num   = (NUM_BITS'(ax) << DEN_BITS) + NUM_BITS'(d_q[DEN_BITS-1:1]);
      end
      ST_DIVX: begin
        div_start = div_done;
        div_num   = (NUM_BITS'(ay) << DEN_BITS) + NUM_BITS'(d_q[DEN_BITS-1:1]);
      end
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_o.red_re    = x_q;
    out_o.red_im    = y_q;
    out_o.saturated = sat_q;
    out_o.in_domain = !y_q[WORD_BITS-1] && (y_q != '0)
                   && (d_q[SQ_BITS-1:DEN_BITS] != '0) && (ax <= FX_HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_rounds_q <= 8'd200;
      rnd_q        <= '0;
      fin_q        <= 1'b0;
      sat_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_rounds_q <= cfg_data_i;
      case (state_q)
        ST_IDLE: if (start) begin
          rnd_q <= '0;
          fin_q <= 1'b0;
          sat_q <= 1'b0;
        end
        ST_ROUND: if (rnd_q == max_rounds_q) fin_q <= 1'b1;
        ST_DIVX:  if (div_done) sat_q <= sat_q | qx_sat;
        ST_DIVY: if (div_done) begin
          sat_q <= sat_q | qy_sat;
          rnd_q <= rnd_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (start) begin
        x_q <= in_i.z_re;
        y_q <= in_i.z_im;
      end
      ST_TRANS: x_q   <= xt[WORD_BITS-1:0];
      ST_SQX:   acc_q <= prod;
      ST_SQY:   d_q   <= acc_q + prod;
      ST_DIVX:  if (div_done) x_q <= qx;
      ST_DIVY:  if (div_done) y_q <= qy;
      default: ;
    endcase
  end

endmodule

// ===== src/mdr_checker.sv =====
// port-level checker for the modular domain reduce core, bound to the top level
// depends on mdr_pkg and modular_domain_reduce_core_macros.svh
`include "modular_domain_reduce_core_macros.svh"
module mdr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input mdr_pkg::out_t out_o
);
  import mdr_pkg::*;

  `MDR_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `MDR_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy)
  `MDR_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy)
  `MDR_ASSERT_IMPL(a_dom_im, clk_i, rst_ni, done_o && out_o.in_domain, !out_o.red_im[WORD_BITS-1] && (out_o.red_im != '0))

endmodule

bind modular_domain_reduce_core mdr_checker u_mdr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .out_o  (out_o)
);

// ===== verif/tb.sv =====
// self-checking testbench for modular_domain_reduce_core
// depends on mdr_pkg and the core; predicts reduced points with its own model or takes them from a table
module tb;
  import mdr_pkg::*;

  localparam longint unsigned SQ_ONE = 64'd1 << (2 * FRAC_BITS);
  localparam longint unsigned FX_HALF = 64'd1 << (FRAC_BITS - 1);
  localparam int IDLE_LIMIT = 200000;
  localparam int RAND_ITEMS = 880;

  typedef struct {
    in_t  pt;
    bit   typed;
    out_t res;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;
  logic       done_o;
  out_t       out_o;

  out_t       pending_q[$];
  logic [7:0] round_limit = 8'd200;
  int         errors = 0;
  int         sent = 0;
  int         checked = 0;
  int         n_dom = 0;
  int         n_sat = 0;
  int         quiet = 0;

  modular_domain_reduce_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i), .done_o(done_o), .out_o(out_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned norm_sq(longint x, longint y);
    longint unsigned ax, ay;
    ax = absval(x);
    ay = absval(y);
    return ax * ax + ay * ay;
  endfunction

  // rounded quotient m / d in Q16.16, sign applied, clamped to the word
  function automatic longint invert_part(bit neg, longint unsigned m,
                                         longint unsigned d, inout bit sat);
    longint unsigned q;
    q = (m * SQ_ONE + d / 2) / d;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return -64'sh8000_0000;
      end
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    return longint'(q);
  endfunction

  function automatic out_t reduce_point(in_t p, logic [7:0] rounds);
    longint x, y, nx, ny, sh;
    longint unsigned d;
    bit sat;
    out_t r;
    x = p.z_re;
    y = p.z_im;
    sat = 1'b0;
    for (int i = 0; i < rounds; i++) begin
      sh = longint'(((absval(x) + FX_HALF) >> FRAC_BITS) << FRAC_BITS);
      x = x < 0 ? x + sh : x - sh;
      d = norm_sq(x, y);
      if (d >= SQ_ONE || d == 0) break;
      nx = invert_part(x > 0, absval(x), d, sat);
      ny = invert_part(y < 0, absval(y), d, sat);
      x = nx;
      y = ny;
    end
    d = norm_sq(x, y);
    r.red_re = x[WORD_BITS-1:0];
    r.red_im = y[WORD_BITS-1:0];
    r.in_domain = (y > 0) && (d >= SQ_ONE) && (absval(x) <= FX_HALF);
    r.saturated = sat;
    return r;
  endfunction

  // results and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet <= (done_o || (start && !busy)) ? 0 : quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout waiting for a transfer");
        $display("[modular_domain_reduce_core] ERROR");
        $finish;
      end
      if (done_o) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing pending");
          errors++;
        end else begin
          out_t e;
          e = pending_q.pop_front();
          checked++;
          if (out_o.in_domain) n_dom++;
          if (out_o.saturated) n_sat++;
          if (out_o.red_re !== e.red_re) begin
            $error("red_re exp %h got %h", e.red_re, out_o.red_re);
            errors++;
          end
          if (out_o.red_im !== e.red_im) begin
            $error("red_im exp %h got %h", e.red_im, out_o.red_im);
            errors++;
          end
          if (out_o.in_domain !== e.in_domain) begin
            $error("in_domain exp %b got %b", e.in_domain, out_o.in_domain);
            errors++;
          end
          if (out_o.saturated !== e.saturated) begin
            $error("saturated exp %b got %b", e.saturated, out_o.saturated);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_point(in_t p, bit typed, out_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= p;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_q.push_back(typed ? res : reduce_point(p, round_limit));
    sent++;
  endtask

  task automatic drain;
    @(posedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_rounds(logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    round_limit = v;
  endtask

  function automatic in_t random_point();
    in_t p;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      p.z_re = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
      p.z_im = $urandom_range(1, 2 << 16);
    end else if (sel < 70) begin
      p.z_re = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
      p.z_im = -$signed($urandom_range(0, 2 << 16));
    end else if (sel < 80) begin
      p.z_re = $signed($urandom_range(0, 16)) - 8;
      p.z_im = $signed($urandom_range(0, 16)) - 8;
    end else begin
      p.z_re = $urandom;
      p.z_im = $urandom;
    end
    return p;
  endfunction

  initial begin
    row_t rows[$];
    logic [7:0] phase_rounds[6];
    out_t none;
    none = '0;
    rows = '{
      '{'{32'sh0, 32'sh0}, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b0}},
      '{'{32'sh0, 32'sh1_0000}, 1'b1, '{32'sh0, 32'sh1_0000, 1'b1, 1'b0}},
      '{'{32'sh8000, 32'sh1_0000}, 1'b1, '{-32'sh8000, 32'sh1_0000, 1'b1, 1'b0}},
      '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1, '{-32'sh1, 32'sh7FFF_FFFF, 1'b1, 1'b0}},
      '{'{32'h8000_0000, 32'h8000_0000}, 1'b1, '{32'sh0, 32'h8000_0000, 1'b0, 1'b0}},
      '{'{32'sh0, 32'sh1}, 1'b1, '{32'sh0, 32'sh7FFF_FFFF, 1'b1, 1'b1}},
      '{'{32'sh0, -32'sh1}, 1'b1, '{32'sh0, 32'h8000_0000, 1'b0, 1'b1}},
      '{'{32'sh0, 32'sh8000}, 1'b0, none},
      '{'{32'sh3000, 32'sh4000}, 1'b0, none},
      '{'{-32'sh3000, 32'sh4000}, 1'b0, none},
      '{'{-32'sh8000, 32'sh1_0000}, 1'b0, none},
      '{'{32'sh1_8000, 32'sh8000}, 1'b0, none},
      '{'{-32'sh1_8000, 32'sh8000}, 1'b0, none},
      '{'{32'sh2_3456, 32'sh0}, 1'b0, none},
      '{'{32'sh0, -32'sh8000}, 1'b0, none},
      '{'{32'sh1, 32'sh0}, 1'b0, none},
      '{'{32'sh7FFF_FFFF, 32'sh1}, 1'b0, none},
      '{'{32'h8000_0000, 32'sh7FFF_FFFF}, 1'b0, none},
      '{'{32'sh5555, 32'sh0_DDB3}, 1'b0, none},
      '{'{32'sh0_0100, 32'sh0_0100}, 1'b0, none}
    };
    phase_rounds = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd200, 8'd0};
    phase_rounds[5] = 8'($urandom_range(2, 40));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].res);
    foreach (phase_rounds[ph]) begin
      write_rounds(phase_rounds[ph]);
      repeat (RAND_ITEMS / 6) send_point(random_point(), 1'b0, none);
    end
    drain();
    $display("%0d points sent, %0d results checked over 7 round limits", sent, checked);
    $display("%0d in domain, %0d saturated, %0d mismatches", n_dom, n_sat, errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[modular_domain_reduce_core] OK");
    end else begin
      $display("[modular_domain_reduce_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== modular_domain_reduce_core.f =====
+incdir+src
src/mdr_pkg.sv
src/mdr_div.sv
src/modular_domain_reduce_core.sv
src/mdr_checker.sv
verif/tb.sv
